/* rtl/core/tlrat_pkg.sv */
// Package for the two-level region address translation block.
// Operation and status codes, table sizes, write bundles and the tokens
// that travel along the segment and mapping cell chains. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlrat_pkg;

  localparam int SEG_ENTRIES_DEF = 8;
  localparam int MAP_ENTRIES_DEF = 16;

  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_WR_SEG    = 2'd1;
  localparam logic [1:0] OP_WR_MAP    = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSEG    = 3'd1;
  localparam logic [2:0] ST_UNMAPPED = 3'd2;
  localparam logic [2:0] ST_DONE     = 3'd3;
  localparam logic [2:0] ST_REJECT   = 3'd4;

  // segment entry contents, broadcast to every segment cell
  typedef struct packed {
    logic [31:0] off;
    logic [31:0] base;
    logic [31:0] len;
  } seg_wr_t;

  // mapping entry contents; span is end - start, worked out once at the top
  typedef struct packed {
    logic [63:0] start;
    logic [63:0] span;
    logic [63:0] moff;
  } map_wr_t;

  // token walking the segment chain
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [31:0] vaddr;
    logic [32:0] foff;
  } seg_tok_t;

  // token walking the mapping chain
  typedef struct packed {
    logic        valid;
    logic        seg_hit;
    logic        found;
    logic [32:0] foff;
    logic [63:0] addr;
  } map_tok_t;

endpackage

`default_nettype wire

/* rtl/core/tlrat_seg_cell.sv */
// One segment table cell: holds a single segment entry and its valid bit.
// Passes the lookup token on each cycle. Depends on tlrat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlrat_seg_cell
  import tlrat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     we,
  input  wire logic     clr,
  input  wire seg_wr_t  wr_data,
  input  wire seg_tok_t tok_in,
  output seg_tok_t      tok_out
);

  logic        valid_r;
  logic [31:0] off_r;
  logic [31:0] base_r;
  logic [31:0] len_r;
  seg_tok_t    tok_r;
  seg_tok_t    tok_nxt;

  logic [32:0] va_diff;
  logic        in_seg;
  logic [32:0] foff;

  always_comb begin
    va_diff = {1'b0, tok_in.vaddr} - {1'b0, base_r};
    // no borrow means vaddr >= base; zero length never matches
    in_seg  = !va_diff[32] && (va_diff[31:0] < len_r);
    foff    = {1'b0, off_r} + {1'b0, va_diff[31:0]};
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.hit && valid_r && in_seg) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.foff = foff;
    end
  end

  always_ff @(posedge clk) begin
    tok_r.hit   <= tok_nxt.hit;
    tok_r.vaddr <= tok_nxt.vaddr;
    tok_r.foff  <= tok_nxt.foff;
    if (we) begin
      off_r  <= wr_data.off;
      base_r <= wr_data.base;
      len_r  <= wr_data.len;
    end
    if (!rst_n) begin
      valid_r     <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
      if (clr) begin
        valid_r <= 1'b0;
      end else if (we) begin
        valid_r <= 1'b1;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

/* rtl/core/tlrat_map_cell.sv */
// One mapping table cell: holds a single mapping entry and its valid bit.
// Passes the offset token on each cycle. Depends on tlrat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlrat_map_cell
  import tlrat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     we,
  input  wire logic     clr,
  input  wire map_wr_t  wr_data,
  input  wire map_tok_t tok_in,
  output map_tok_t      tok_out
);

  logic        valid_r;
  logic [63:0] start_r;
  logic [63:0] span_r;
  logic [63:0] moff_r;
  map_tok_t    tok_r;
  map_tok_t    tok_nxt;

  logic [64:0] off_diff;
  logic        covers;

  always_comb begin
    off_diff = {32'd0, tok_in.foff} - {1'b0, moff_r};
    covers   = !off_diff[64] && (off_diff[63:0] < span_r);
    tok_nxt  = tok_in;
    if (tok_in.valid && tok_in.seg_hit && !tok_in.found && valid_r && covers) begin
      tok_nxt.found = 1'b1;
      tok_nxt.addr  = start_r + off_diff[63:0];
    end
  end

  always_ff @(posedge clk) begin
    tok_r.seg_hit <= tok_nxt.seg_hit;
    tok_r.found   <= tok_nxt.found;
    tok_r.foff    <= tok_nxt.foff;
    tok_r.addr    <= tok_nxt.addr;
    if (we) begin
      start_r <= wr_data.start;
      span_r  <= wr_data.span;
      moff_r  <= wr_data.moff;
    end
    if (!rst_n) begin
      valid_r     <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
      if (clr) begin
        valid_r <= 1'b0;
      end else if (we) begin
        valid_r <= 1'b1;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

/* rtl/core/two_level_region_address_translation.sv */
// Top level of the two-level region address translation block.
// Instantiates the segment cell chain and the mapping cell chain.
// Depends on tlrat_pkg, tlrat_seg_cell and tlrat_map_cell.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   operation, index, entry fields, address
//   out_     output     out_valid/out_stall runtime_address, status
//
// The result of a write or clear is registered at the transfer edge and
// shown on the next cycle.
// A translate walks a token through SEG_ENTRIES segment cells and then
// MAP_ENTRIES mapping cells, one cell per cycle, and then into the output
// register; no new item is taken until that result has been registered.
// Reset clears the valid bits, the token valids and the output valid bit;
// entry contents and output data are left as they are. A stalled result
// blocks new input.
`timescale 1ns / 1ps
`default_nettype none

module two_level_region_address_translation
  import tlrat_pkg::*;
#(
  parameter int SEG_ENTRIES = SEG_ENTRIES_DEF,
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic [31:0] in_segment_file_offset,
  input  wire logic [31:0] in_segment_base,
  input  wire logic [31:0] in_segment_length,
  input  wire logic [63:0] in_mapping_start,
  input  wire logic [63:0] in_mapping_end,
  input  wire logic [63:0] in_mapping_file_offset,
  input  wire logic [31:0] in_lookup_address,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_runtime_address,
  output logic [2:0]       out_status
);

  // ---------------------------------------------------------------------
  // Handshake and control
  // ---------------------------------------------------------------------
  logic        busy_r;
  logic        busy_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [63:0] out_addr_r;
  logic [63:0] out_addr_nxt;
  logic [2:0]  out_status_r;
  logic [2:0]  out_status_nxt;
  logic        accept;

  // only one item is in flight; the output register must be free or draining
  assign in_stall = busy_r | (out_valid_r & out_stall);
  assign accept   = in_valid & ~in_stall;

  // ---------------------------------------------------------------------
  // Write decode
  // ---------------------------------------------------------------------
  logic    seg_idx_ok;
  logic    map_idx_ok;
  logic    map_nonempty;
  logic    seg_wr;
  logic    map_wr;
  logic    tbl_clr;
  seg_wr_t seg_wdata;
  map_wr_t map_wdata;

  assign seg_idx_ok   = int'(in_entry_index) < SEG_ENTRIES;
  assign map_idx_ok   = int'(in_entry_index) < MAP_ENTRIES;
  assign map_nonempty = in_mapping_end > in_mapping_start;

  assign seg_wr  = accept && (in_operation == OP_WR_SEG) && seg_idx_ok;
  assign map_wr  = accept && (in_operation == OP_WR_MAP) && map_idx_ok && map_nonempty;
  assign tbl_clr = accept && (in_operation == OP_CLEAR);

  assign seg_wdata.off  = in_segment_file_offset;
  assign seg_wdata.base = in_segment_base;
  assign seg_wdata.len  = in_segment_length;

  // span is only stored when end > start, so it never wraps
  assign map_wdata.start = in_mapping_start;
  assign map_wdata.span  = in_mapping_end - in_mapping_start;
  assign map_wdata.moff  = in_mapping_file_offset;

  // ---------------------------------------------------------------------
  // Segment chain: first cell to match marks the token, later cells pass it
  // ---------------------------------------------------------------------
  seg_tok_t seg_tok [SEG_ENTRIES+1];
  map_tok_t map_tok [MAP_ENTRIES+1];

  assign seg_tok[0].valid = accept && (in_operation == OP_TRANSLATE);
  assign seg_tok[0].hit   = 1'b0;
  assign seg_tok[0].vaddr = in_lookup_address;
  assign seg_tok[0].foff  = '0;

  for (genvar i = 0; i < SEG_ENTRIES; i++) begin : g_seg
    logic we;
    assign we = seg_wr && ({28'd0, in_entry_index} == 32'(i));

    tlrat_seg_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .we      (we),
      .clr     (tbl_clr),
      .wr_data (seg_wdata),
      .tok_in  (seg_tok[i]),
      .tok_out (seg_tok[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Mapping chain: offset from the winning segment looks for its mapping
  // ---------------------------------------------------------------------
  assign map_tok[0].valid   = seg_tok[SEG_ENTRIES].valid;
  assign map_tok[0].seg_hit = seg_tok[SEG_ENTRIES].hit;
  assign map_tok[0].found   = 1'b0;
  assign map_tok[0].foff    = seg_tok[SEG_ENTRIES].foff;
  assign map_tok[0].addr    = '0;

  for (genvar j = 0; j < MAP_ENTRIES; j++) begin : g_map
    logic we;
    assign we = map_wr && ({28'd0, in_entry_index} == 32'(j));

    tlrat_map_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .we      (we),
      .clr     (tbl_clr),
      .wr_data (map_wdata),
      .tok_in  (map_tok[j]),
      .tok_out (map_tok[j+1])
    );
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  map_tok_t tail;
  assign tail = map_tok[MAP_ENTRIES];

  always_comb begin
    busy_nxt       = busy_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;

    if (tail.valid) begin
      // translate finished: the output register is free by construction
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (!tail.seg_hit) begin
        out_status_nxt = ST_NOSEG;
        out_addr_nxt   = '0;
      end else if (!tail.found) begin
        out_status_nxt = ST_UNMAPPED;
        out_addr_nxt   = '0;
      end else begin
        out_status_nxt = ST_OK;
        out_addr_nxt   = tail.addr;
      end
    end

    if (accept) begin
      case (in_operation)
        OP_TRANSLATE: begin
          busy_nxt = 1'b1;
        end
        OP_WR_SEG: begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = seg_idx_ok ? ST_DONE : ST_REJECT;
        end
        OP_WR_MAP: begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = (map_idx_ok && map_nonempty) ? ST_DONE : ST_REJECT;
        end
        default: begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_runtime_address = out_addr_r;
  assign out_status          = out_status_r;

endmodule

`default_nettype wire

/* rtl/core/tlrat_checker.sv */
// Port-level checker for the two-level region address translation block,
// bound to the top level. Depends on tlrat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlrat_checker
  import tlrat_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_operation,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_runtime_address,
  input wire logic [2:0]  out_status
);

  // a write or clear yields its result on the very next cycle
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation != OP_TRANSLATE) |=>
      out_valid && (out_status == ST_DONE || out_status == ST_REJECT)
      && (out_runtime_address == 64'd0))
    else $error("write transfer without matching result");

  // anything but a translated result carries a zero address
  a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_runtime_address == 64'd0)
    else $error("non-zero address on miss or write");

  // codes above write rejected are never shown
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_REJECT))
    else $error("status code out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_status) && $stable(out_runtime_address))
    else $error("stalled result changed");

endmodule

bind two_level_region_address_translation tlrat_checker u_tlrat_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_operation        (in_operation),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_runtime_address (out_runtime_address),
  .out_status          (out_status)
);

`default_nettype wire

/* tb/two_level_region_address_translation_tb.sv */
// Self-checking testbench for two_level_region_address_translation.
// Holds its own model of the segment and mapping tables in a small scoreboard
// class; depends on tlrat_pkg and the block's RTL only.
`timescale 1ns / 1ps

module two_level_region_address_translation_tb;
  import tlrat_pkg::*;

  localparam int TOTAL_ITEMS   = 1050;
  localparam int LIMIT_CYCLES  = 400000;
  // leave room for stray results after the last expected one
  localparam int SETTLE_CYCLES = 64;

  // one input transfer, every field as driven onto the ports
  typedef struct {
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [31:0] seg_off;
    logic [31:0] seg_base;
    logic [31:0] seg_len;
    logic [63:0] map_start;
    logic [63:0] map_end;
    logic [63:0] map_off;
    logic [31:0] lookup;
  } xlate_req_t;

  typedef struct {
    logic [63:0] addr;
    logic [2:0]  status;
  } xlate_resp_t;

  // Scoreboard: shadow copy of both tables, predicted results in order of
  // input transfer, and the mismatch count.
  class translation_scoreboard;
    logic [31:0] seg_file_off[SEG_ENTRIES_DEF];
    logic [31:0] seg_base[SEG_ENTRIES_DEF];
    logic [31:0] seg_len[SEG_ENTRIES_DEF];
    bit          seg_live[SEG_ENTRIES_DEF];
    logic [63:0] map_start[MAP_ENTRIES_DEF];
    logic [63:0] map_stop[MAP_ENTRIES_DEF];
    logic [63:0] map_file_off[MAP_ENTRIES_DEF];
    bit          map_live[MAP_ENTRIES_DEF];
    xlate_resp_t expected_results[$];
    int          errors;

    // lowest live segment holding va decides; its file offset must then sit in
    // the lowest live mapping that covers it, or the lookup is unmapped
    function logic [2:0] walk_tables(input logic [31:0] va, output logic [63:0] ra);
      logic [32:0] seg_limit;
      logic [63:0] foff;
      logic [63:0] span;
      ra = '0;
      for (int i = 0; i < SEG_ENTRIES_DEF; i++) begin
        if (!seg_live[i]) continue;
        seg_limit = {1'b0, seg_base[i]} + {1'b0, seg_len[i]};
        if (va < seg_base[i] || {1'b0, va} >= seg_limit) continue;
        foff = 64'({1'b0, seg_file_off[i]} + {1'b0, va - seg_base[i]});
        for (int j = 0; j < MAP_ENTRIES_DEF; j++) begin
          if (!map_live[j]) continue;
          span = map_stop[j] - map_start[j];
          if (foff >= map_file_off[j] && foff - map_file_off[j] < span) begin
            ra = map_start[j] + (foff - map_file_off[j]);
            return ST_OK;
          end
        end
        return ST_UNMAPPED;
      end
      return ST_NOSEG;
    endfunction

    function void note_request(input xlate_req_t r);
      xlate_resp_t exp_r;
      exp_r.addr   = '0;
      exp_r.status = ST_DONE;
      case (r.op)
        OP_TRANSLATE: exp_r.status = walk_tables(r.lookup, exp_r.addr);
        OP_WR_SEG: begin
          if (r.idx < SEG_ENTRIES_DEF) begin
            seg_file_off[r.idx] = r.seg_off;
            seg_base[r.idx]     = r.seg_base;
            seg_len[r.idx]      = r.seg_len;
            seg_live[r.idx]     = 1'b1;
          end else begin
            exp_r.status = ST_REJECT;
          end
        end
        OP_WR_MAP: begin
          if (r.idx < MAP_ENTRIES_DEF && r.map_end > r.map_start) begin
            map_start[r.idx]    = r.map_start;
            map_stop[r.idx]     = r.map_end;
            map_file_off[r.idx] = r.map_off;
            map_live[r.idx]     = 1'b1;
          end else begin
            exp_r.status = ST_REJECT;
          end
        end
        default: begin
          foreach (seg_live[i]) seg_live[i] = 1'b0;
          foreach (map_live[i]) map_live[i] = 1'b0;
        end
      endcase
      expected_results.insert(expected_results.size(), exp_r);
    endfunction

    task report_mismatch(input string msg);
      $display("%0t ns MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_result(input logic [63:0] addr, input logic [2:0] status);
      xlate_resp_t exp_r;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result addr=%h status=%0d with nothing outstanding",
                                  addr, status));
      end else begin
        exp_r = expected_results.pop_front();
        if (status !== exp_r.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, exp_r.status));
        if (addr !== exp_r.addr)
          report_mismatch($sformatf("runtime_address %h, expected %h", addr, exp_r.addr));
      end
    endtask

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_TRANSLATE;
  logic [3:0]  in_entry_index = '0;
  logic [31:0] in_segment_file_offset = '0;
  logic [31:0] in_segment_base = '0;
  logic [31:0] in_segment_length = '0;
  logic [63:0] in_mapping_start = '0;
  logic [63:0] in_mapping_end = '0;
  logic [63:0] in_mapping_file_offset = '0;
  logic [31:0] in_lookup_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_runtime_address;
  logic [2:0]  out_status;

  translation_scoreboard scoreboard = new();

  // sender pacing
  int burst_left = 0;
  int sent = 0;
  // receiver pacing
  int rx_cycle = 0;
  int hold_left = 0;
  int stall_mode = 0;
  logic stall_next;
  int cycle_count = 0;

  // what the stimulus last wrote into each segment slot, so that lookups and
  // mapping offsets can be aimed at live regions
  logic [31:0] aim_base[SEG_ENTRIES_DEF];
  logic [31:0] aim_len[SEG_ENTRIES_DEF];
  logic [31:0] aim_off[SEG_ENTRIES_DEF];

  two_level_region_address_translation dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_operation           (in_operation),
    .in_entry_index         (in_entry_index),
    .in_segment_file_offset (in_segment_file_offset),
    .in_segment_base        (in_segment_base),
    .in_segment_length      (in_segment_length),
    .in_mapping_start       (in_mapping_start),
    .in_mapping_end         (in_mapping_end),
    .in_mapping_file_offset (in_mapping_file_offset),
    .in_lookup_address      (in_lookup_address),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_runtime_address    (out_runtime_address),
    .out_status             (out_status)
  );

  always #5 clk = ~clk;

  // Watchdog: anything that hangs the handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("two_level_region_address_translation_tb NOT OK");
      $finish;
    end
  end

  // Receiver. Samples the result channel at the edge (values from before the
  // edge, as the block drives them), then picks the stall for the next cycle.
  // The pattern is redrawn from four: none, light random, periodic, heavy
  // random. Twice in the run it holds off while the sender keeps offering,
  // so a result stays stalled and in_stall has to rise.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      scoreboard.check_result(out_runtime_address, out_status);
    rx_cycle++;
    if (hold_left > 0)
      hold_left--;
    else if (rx_cycle == 2000 || rx_cycle == 12000)
      hold_left = 400;
    if (rx_cycle % 500 == 0)
      stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       stall_next = 1'b0;
      1:       stall_next = ($urandom_range(0, 3) == 0);
      2:       stall_next = (rx_cycle % 5) < 2;
      default: stall_next = ($urandom_range(0, 9) < 7);
    endcase
    out_stall <= (hold_left > 0) || stall_next;
  end

  // Every field random; the builders below overwrite what their operation
  // uses, so the ignored fields still toggle.
  function automatic xlate_req_t random_fill();
    xlate_req_t r;
    r.op        = 2'($urandom);
    r.idx       = 4'($urandom);
    r.seg_off   = $urandom;
    r.seg_base  = $urandom;
    r.seg_len   = $urandom;
    r.map_start = {$urandom, $urandom};
    r.map_end   = {$urandom, $urandom};
    r.map_off   = {$urandom, $urandom};
    r.lookup    = $urandom;
    return r;
  endfunction

  function automatic xlate_req_t mk_seg(input logic [3:0] idx, input logic [31:0] off,
                                        input logic [31:0] base, input logic [31:0] len);
    xlate_req_t r;
    r = random_fill();
    r.op       = OP_WR_SEG;
    r.idx      = idx;
    r.seg_off  = off;
    r.seg_base = base;
    r.seg_len  = len;
    return r;
  endfunction

  function automatic xlate_req_t mk_map(input logic [3:0] idx, input logic [63:0] start,
                                        input logic [63:0] stop, input logic [63:0] off);
    xlate_req_t r;
    r = random_fill();
    r.op        = OP_WR_MAP;
    r.idx       = idx;
    r.map_start = start;
    r.map_end   = stop;
    r.map_off   = off;
    return r;
  endfunction

  function automatic xlate_req_t mk_lookup(input logic [31:0] va);
    xlate_req_t r;
    r = random_fill();
    r.op     = OP_TRANSLATE;
    r.lookup = va;
    return r;
  endfunction

  function automatic xlate_req_t mk_clear();
    xlate_req_t r;
    r = random_fill();
    r.op = OP_CLEAR;
    return r;
  endfunction

  // Offer one item and wait for its transfer. Items go out in bursts; valid
  // only drops when a real gap follows, so it is never lowered and raised in
  // the same step.
  task automatic send_request(input xlate_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid               <= 1'b1;
    in_operation           <= r.op;
    in_entry_index         <= r.idx;
    in_segment_file_offset <= r.seg_off;
    in_segment_base        <= r.seg_base;
    in_segment_length      <= r.seg_len;
    in_mapping_start       <= r.map_start;
    in_mapping_end         <= r.map_end;
    in_mapping_file_offset <= r.map_off;
    in_lookup_address      <= r.lookup;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    scoreboard.note_request(r);
    sent++;
  endtask

  initial begin
    xlate_req_t  r;
    int          nseg;
    int          nmap;
    int          nlook;
    int          s;
    int          cap;
    logic [63:0] span;
    logic [63:0] moff;

    foreach (aim_base[i]) begin
      aim_base[i] = '0;
      aim_len[i]  = '0;
      aim_off[i]  = '0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // empty tables: nothing can be found
    send_request(mk_lookup(32'h0000_0000));
    send_request(mk_lookup(32'hFFFF_FFFF));
    send_request(mk_seg(4'd0, 32'h0000_2000, 32'h0000_1000, 32'h0000_0100));
    // segment slots past the table end are refused
    send_request(mk_seg(4'd8, 32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF));
    send_request(mk_seg(4'd15, 32'h0, 32'h0, 32'h1));
    // segment hit but no mapping at all
    send_request(mk_lookup(32'h0000_1000));
    send_request(mk_map(4'd0, 64'h7FFF_0000_0000_0000, 64'h7FFF_0000_0000_0100,
                        64'h0000_0000_0000_2000));
    // empty and inverted mappings are refused
    send_request(mk_map(4'd1, 64'h0000_0000_0000_5000, 64'h0000_0000_0000_5000, 64'h0));
    send_request(mk_map(4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h0));
    // both ends of the segment, and one byte either side
    send_request(mk_lookup(32'h0000_1000));
    send_request(mk_lookup(32'h0000_10FF));
    send_request(mk_lookup(32'h0000_1100));
    send_request(mk_lookup(32'h0000_0FFF));
    // zero-length segment holds nothing
    send_request(mk_seg(4'd1, 32'h0, 32'h0000_5000, 32'h0));
    send_request(mk_lookup(32'h0000_5000));
    // top of the address space: segment limit and file offset need the 33rd bit
    send_request(mk_seg(4'd7, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF));
    send_request(mk_map(4'd15, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF,
                        64'h0000_0001_0000_0000));
    send_request(mk_lookup(32'hFFFF_FFFF));
    // first containing segment is final even when a later one would map
    send_request(mk_seg(4'd2, 32'h0000_2000, 32'h0000_1000, 32'h0000_0100));
    send_request(mk_seg(4'd0, 32'h9000_0000, 32'h0000_1000, 32'h0000_0100));
    send_request(mk_lookup(32'h0000_1080));
    // whole-space mapping catches it
    send_request(mk_map(4'd3, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0));
    send_request(mk_lookup(32'h0000_1080));
    send_request(mk_clear());
    send_request(mk_lookup(32'h0000_1080));

    // ---- random part ----
    // Mostly sessions: maybe a clear, a few segments, mappings aimed at their
    // file offsets, then lookups aimed at the segments. Now and then pure noise.
    while (sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_request(random_fill());
      end else begin
        if ($urandom_range(0, 3) == 0)
          send_request(mk_clear());

        nseg = $urandom_range(1, 4);
        repeat (nseg) begin
          r = random_fill();
          r.op  = OP_WR_SEG;
          r.idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                              : 4'($urandom_range(0, 7));
          case ($urandom_range(0, 3))
            0:       r.seg_base = $urandom;
            1:       r.seg_base = 32'hFFFF_0000 | ($urandom & 32'h0000_FFFF);
            default: r.seg_base = $urandom & 32'h0003_FFFF;
          endcase
          case ($urandom_range(0, 5))
            0:       r.seg_len = '0;
            1:       r.seg_len = $urandom;
            default: r.seg_len = $urandom_range(1, 32'h4000);
          endcase
          r.seg_off = ($urandom_range(0, 2) == 0) ? ($urandom | 32'hFFFF_0000)
                                                  : ($urandom & 32'h000F_FFFF);
          if (r.idx < SEG_ENTRIES_DEF) begin
            aim_base[r.idx] = r.seg_base;
            aim_len[r.idx]  = r.seg_len;
            aim_off[r.idx]  = r.seg_off;
          end
          send_request(r);
        end

        nmap = $urandom_range(1, 5);
        repeat (nmap) begin
          s    = $urandom_range(0, SEG_ENTRIES_DEF - 1);
          cap  = (aim_len[s] > 32'h8000) ? 32'h8000 : aim_len[s];
          moff = 64'(aim_off[s]) + 64'($urandom_range(0, cap)) - 64'($urandom_range(0, 32'h200));
          span = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                             : 64'($urandom_range(1, 32'h1_0000));
          r = mk_map(4'($urandom), {$urandom, $urandom}, '0, moff);
          case ($urandom_range(0, 9))
            0:       r.map_end = r.map_start;
            1:       r.map_end = r.map_start - 64'($urandom_range(1, 32'hFFFF));
            default: r.map_end = r.map_start + span;
          endcase
          send_request(r);
        end

        nlook = $urandom_range(3, 12);
        repeat (nlook) begin
          s   = $urandom_range(0, SEG_ENTRIES_DEF - 1);
          cap = (aim_len[s] > 32'h8000) ? 32'h8000 : aim_len[s];
          if ($urandom_range(0, 7) == 0)
            send_request(mk_lookup($urandom));
          else
            send_request(mk_lookup(aim_base[s] + $urandom_range(0, cap + 2) - 32'd2));
        end
      end
    end
    in_valid <= 1'b0;

    // drain, then give any stray result time to show up
    while (scoreboard.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (scoreboard.errors == 0)
      $display("two_level_region_address_translation_tb OK");
    else
      $display("two_level_region_address_translation_tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
rtl/core/tlrat_pkg.sv
rtl/core/tlrat_seg_cell.sv
rtl/core/tlrat_map_cell.sv
rtl/core/two_level_region_address_translation.sv
rtl/core/tlrat_checker.sv
tb/two_level_region_address_translation_tb.sv
